// File: hw/rtl/parallel_strobe_ack_link_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the parallel strobe/ack link
// Clocked on clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef PARALLEL_STROBE_ACK_LINK_ASSERT_SVH
`define PARALLEL_STROBE_ACK_LINK_ASSERT_SVH

// Same-cycle implication.
`define PSAL_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSAL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/psal_pkg.sv
// ---------------------------------------------------------------------------
// psal_pkg
// Types and constants for the parallel strobe/ack link.
// ---------------------------------------------------------------------------
package psal_pkg;

  localparam int unsigned TICKS_PER_UNIT_DEF = 2;
  localparam int unsigned TICK_W             = 17;
  localparam int unsigned TIMEOUT_W          = 16;
  localparam logic [7:0]  PORT_PULLUPS       = 8'hff;

  typedef enum logic [3:0] {
    OP_POLL    = 4'd0,
    OP_RESET   = 4'd1,
    OP_STROBE  = 4'd2,
    OP_ACKED   = 4'd3,
    OP_INPUT   = 4'd4,
    OP_OUTPUT  = 4'd5,
    OP_READ    = 4'd6,
    OP_WRITE   = 4'd7,
    OP_SEND    = 4'd8,
    OP_RECEIVE = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_WAIT    = 2'd1,
    ST_DONE    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] data_byte;
    logic       ack_level;
    logic [7:0] port_in;
    logic       timer_tick;
  } link_in_t;

  typedef struct packed {
    logic [7:0] port_drive;
    logic       port_output_enable;
    logic       strobe_pulse;
    logic       target_reset_pulse;
    logic [7:0] read_data;
    logic       acked;
    logic [1:0] status;
  } link_out_t;

endpackage

// File: hw/rtl/parallel_strobe_ack_link.sv
// ---------------------------------------------------------------------------
// parallel_strobe_ack_link
// Host side of an 8-bit parallel link with strobe out and toggling ack in.
// Takes one request per clock while in_ready is high and returns exactly
// one result per request. A two-entry output buffer (result register
// plus skid register) keeps accepting one more request after out_ready
// drops; in_ready falls only once both entries are full. Send and receive
// waits span later requests, each of which acts as a poll and counts
// timer_tick; the timeout limit is timeout_units * TICKS_PER_UNIT ticks,
// zero meaning no limit. Write timeout_units only while the link is idle.
// ---------------------------------------------------------------------------
`include "parallel_strobe_ack_link_assert.svh"

module parallel_strobe_ack_link
  import psal_pkg::*;
#(
  parameter int unsigned TICKS_PER_UNIT = TICKS_PER_UNIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [TIMEOUT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  link_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output link_out_t            out_data
);

  typedef enum logic [1:0] {
    WAIT_IDLE = 2'd0,
    WAIT_SEND = 2'd1,
    WAIT_RECV = 2'd2
  } wait_t;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam int unsigned       LIMIT_W  = TIMEOUT_W + $clog2(TICKS_PER_UNIT + 1);

  logic [TIMEOUT_W-1:0] timeout_units;
  wait_t                mode, mode_next;
  logic                 last_ack, last_ack_next;
  logic                 drive_enable, drive_enable_next;
  logic [7:0]           port_latch, port_latch_next;
  logic [TICK_W-1:0]    tick_count, tick_count_next;
  logic [LIMIT_W-1:0]   tick_limit;
  logic                 check;
  link_out_t            res;
  link_out_t            skid;
  logic                 skid_valid;
  logic                 fire, pop;

  assign in_ready = !skid_valid;
  assign fire     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // tick_count / TICKS_PER_UNIT >= timeout_units  <=>  tick_count >= limit
  assign tick_limit = LIMIT_W'(timeout_units) * LIMIT_W'(TICKS_PER_UNIT);

  always_comb begin
    mode_next         = mode;
    last_ack_next     = last_ack;
    drive_enable_next = drive_enable;
    port_latch_next   = port_latch;
    tick_count_next   = tick_count;
    check             = 1'b0;
    res               = '0;

    if (mode == WAIT_SEND || mode == WAIT_RECV) begin
      if (in_data.timer_tick && tick_count != TICK_MAX) begin
        tick_count_next = tick_count + 1'b1;
      end
      check = 1'b1;
    end else begin
      mode_next = WAIT_IDLE;
      case (op_t'(in_data.op))
        OP_RESET:  res.target_reset_pulse = 1'b1;
        OP_STROBE: res.strobe_pulse = 1'b1;
        OP_ACKED: begin
          if (in_data.ack_level != last_ack) begin
            res.acked     = 1'b1;
            last_ack_next = in_data.ack_level;
          end
        end
        OP_INPUT: begin
          drive_enable_next = 1'b0;
          port_latch_next   = PORT_PULLUPS;
        end
        OP_OUTPUT: drive_enable_next = 1'b1;
        OP_READ:   res.read_data = in_data.port_in;
        OP_WRITE:  port_latch_next = in_data.data_byte;
        OP_SEND: begin
          port_latch_next  = in_data.data_byte;
          res.strobe_pulse = 1'b1;
          tick_count_next  = '0;
          mode_next        = WAIT_SEND;
          check            = 1'b1;
        end
        OP_RECEIVE: begin
          tick_count_next = '0;
          mode_next       = WAIT_RECV;
          check           = 1'b1;
        end
        default: ;
      endcase
    end

    if (check) begin
      if (timeout_units != '0 && LIMIT_W'(tick_count_next) >= tick_limit) begin
        res.status = ST_TIMEOUT;
        mode_next  = WAIT_IDLE;
      end else if (in_data.ack_level != last_ack_next) begin
        last_ack_next = in_data.ack_level;
        if (mode_next == WAIT_RECV) begin
          res.read_data    = in_data.port_in;
          res.strobe_pulse = 1'b1;
        end
        res.status = ST_DONE;
        mode_next  = WAIT_IDLE;
      end else begin
        res.status = ST_WAIT;
      end
    end

    res.port_drive         = port_latch_next;
    res.port_output_enable = drive_enable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_units <= '0;
      mode          <= WAIT_IDLE;
      last_ack      <= 1'b1;
      drive_enable  <= 1'b0;
      port_latch    <= PORT_PULLUPS;
      tick_count    <= '0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        timeout_units <= cfg_data;
      end
      if (fire) begin
        mode         <= mode_next;
        last_ack     <= last_ack_next;
        drive_enable <= drive_enable_next;
        port_latch   <= port_latch_next;
        tick_count   <= tick_count_next;
      end
      if (pop) begin
        if (skid_valid) begin
          out_data   <= skid;
          skid_valid <= 1'b0;
        end else if (fire) begin
          out_data <= res;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (fire) begin
        if (out_valid) begin
          skid       <= res;
          skid_valid <= 1'b1;
        end else begin
          out_data  <= res;
          out_valid <= 1'b1;
        end
      end
    end
  end

  `PSAL_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid full while output empty")
  `PSAL_ASSERT_NEXT(a_skid_drains, pop && skid_valid, out_valid && !skid_valid, "skid not drained")
  `PSAL_ASSERT_NEXT(a_cmd_clears_timer, fire && check && mode == WAIT_IDLE, tick_count == '0, "timer not cleared")
  `PSAL_ASSERT_NEXT(a_wait_holds, fire && res.status == ST_WAIT, mode != WAIT_IDLE, "wait status while idle")
  `PSAL_ASSERT_NEXT(a_wait_keeps_dir, fire && mode != WAIT_IDLE, $stable(drive_enable), "direction changed in wait")

endmodule
